/* design/srs_pkg.sv */
// Shared types and constants for the signed radix sorter.
package srs_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DIGIT_BITS = 11;
    localparam int VALUE_W        = 32;
    localparam logic [VALUE_W-1:0] SIGN_FLIP = 32'h8000_0000;
    localparam logic [1:0] ADDR_DESCENDING = 2'd0;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_COUNT,
        ST_PREFIX,
        ST_SCATTER,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic start_sort;
        logic start_clear;
        logic clear_step;
        logic count_step;
        logic prefix_step;
        logic scatter_step;
        logic next_pass;
        logic emit_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic count_done;
        logic prefix_done;
        logic scatter_done;
        logic sort_done;
        logic emit_last;
    } status_t;

endpackage

/* design/srs_if.sv */
// Valid/ready stream interfaces for the sorter's input and output channels.
interface srs_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        is_last;
    modport source (output valid, output value, output is_last, input ready);
    modport sink (input valid, input value, input is_last, output ready);
endinterface

interface srs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sorted_value;
    logic        end_of_set;
    logic        dropped;
    modport source (output valid, output sorted_value, output end_of_set, output dropped,
                    input ready);
    modport sink (input valid, input sorted_value, input end_of_set, input dropped,
                  output ready);
endinterface

/* design/srs_ctrl.sv */
// Sequencing state machine for load, clear, count, prefix, scatter and emit.
module srs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic             in_last,
    input  logic             out_busy,
    input  srs_pkg::status_t status,
    output srs_pkg::cmd_t    cmd,
    output logic             in_ready,
    output logic             emitting
);
    import srs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        emitting = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        cmd.start_sort = 1'b1;
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                cmd.count_step = 1'b1;
                if (status.count_done)
                begin
                    state_next = ST_PREFIX;
                end
            end
            ST_PREFIX:
            begin
                cmd.prefix_step = 1'b1;
                if (status.prefix_done)
                begin
                    state_next = ST_SCATTER;
                end
            end
            ST_SCATTER:
            begin
                cmd.scatter_step = 1'b1;
                if (status.scatter_done)
                begin
                    cmd.next_pass = 1'b1;
                    if (status.sort_done)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.start_clear = 1'b1;
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_EMIT:
            begin
                emitting = 1'b1;
                if (!out_busy)
                begin
                    cmd.emit_step = 1'b1;
                    if (status.emit_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end
endmodule

/* design/srs_datapath.sv */
// Element buffers, bucket count memory and pass counters of the sorter.
module srs_datapath #(
    parameter int CAPACITY   = srs_pkg::DEF_CAPACITY,
    parameter int DIGIT_BITS = srs_pkg::DEF_DIGIT_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  srs_pkg::cmd_t    cmd,
    input  logic [31:0]      in_value,
    input  logic             descending,
    output srs_pkg::status_t status,
    output logic             emit_valid,
    output logic [31:0]      emit_value,
    output logic             emit_end,
    output logic             emit_dropped
);
    import srs_pkg::*;

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int BKT    = 1 << DIGIT_BITS;
    localparam int SH_W   = 6;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic [31:0] buf_a [CAPACITY];
    logic [31:0] buf_b [CAPACITY];
    logic [CNT_W-1:0] bkt_mem [BKT];

    logic [CNT_W-1:0]      count_reg;
    logic                  over_reg;
    logic                  src_b_reg;
    logic [SH_W-1:0]       shift_reg;
    logic [DIGIT_BITS:0]   bidx_reg;
    logic [CNT_W-1:0]      eidx_reg;
    logic [CNT_W-1:0]      sum_reg;
    logic                  phase_reg;
    logic [31:0]           rd_reg;
    logic [CNT_W-1:0]      brd_reg;
    logic                  desc_reg;

    logic [31:0]           src_word;
    logic [31:0]           shifted;
    logic [DIGIT_BITS-1:0] digit;
    logic [SH_W:0]         bits_left;
    logic [SH_W-1:0]       step_bits;
    logic [31:0]           dmask;
    logic [IDX_W-1:0]      rd_idx;
    logic [CNT_W-1:0]      last_idx;

    assign last_idx  = count_reg - CNT_W'(1);
    assign bits_left = (SH_W+1)'(32) - {1'b0, shift_reg};
    assign step_bits = (bits_left > (SH_W+1)'(DIGIT_BITS)) ? SH_W'(DIGIT_BITS)
                                                           : bits_left[SH_W-1:0];
    assign dmask     = (32'd1 << step_bits) - 32'd1;
    // buffers hold signed words; digits are taken with the sign bit flipped
    assign shifted   = (rd_reg ^ SIGN_FLIP) >> shift_reg;
    assign digit     = DIGIT_BITS'(shifted & dmask);

    // emit index: ascending reads k, descending reads n-1-k
    // count and scatter fetch the next element in their write cycle
    always_comb
    begin
        rd_idx = IDX_W'(eidx_reg);
        if ((cmd.count_step || cmd.scatter_step) && phase_reg)
        begin
            rd_idx = IDX_W'(eidx_reg + CNT_W'(1));
        end
        else if (desc_reg && !(cmd.clear_step || cmd.count_step || cmd.prefix_step ||
                               cmd.scatter_step))
        begin
            rd_idx = IDX_W'(last_idx - eidx_reg);
        end
    end

    assign src_word = src_b_reg ? buf_b[rd_idx] : buf_a[rd_idx];

    always_ff @(posedge clk)
    begin
        rd_reg <= src_word;
        if (cmd.load && count_reg < CAP_C)
        begin
            buf_a[IDX_W'(count_reg)] <= in_value;
        end
        if (cmd.scatter_step && phase_reg)
        begin
            if (src_b_reg)
            begin
                buf_a[IDX_W'(brd_reg)] <= rd_reg;
            end
            else
            begin
                buf_b[IDX_W'(brd_reg)] <= rd_reg;
            end
        end
    end

    // bucket memory: one read and one write port
    logic [DIGIT_BITS-1:0] b_waddr;
    logic [CNT_W-1:0]      b_wdata;
    logic                  b_we;
    logic [DIGIT_BITS-1:0] b_raddr;

    always_comb
    begin
        b_we    = 1'b0;
        b_waddr = digit;
        b_wdata = brd_reg + CNT_W'(1);
        b_raddr = digit;
        if (cmd.clear_step)
        begin
            b_we    = 1'b1;
            b_waddr = bidx_reg[DIGIT_BITS-1:0];
            b_wdata = '0;
        end
        else if (cmd.count_step || cmd.scatter_step)
        begin
            b_we = phase_reg;
        end
        else if (cmd.prefix_step)
        begin
            b_raddr = bidx_reg[DIGIT_BITS-1:0];
            b_we    = phase_reg;
            b_waddr = bidx_reg[DIGIT_BITS-1:0];
            b_wdata = sum_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        brd_reg <= bkt_mem[b_raddr];
        if (b_we)
        begin
            bkt_mem[b_waddr] <= b_wdata;
        end
    end

    logic [DIGIT_BITS:0] bkt_last;
    assign bkt_last = (DIGIT_BITS+1)'(dmask);

    assign status.clear_done   = bidx_reg == (DIGIT_BITS+1)'(BKT - 1);
    assign status.count_done   = phase_reg && (eidx_reg == last_idx);
    assign status.prefix_done  = phase_reg && (bidx_reg == bkt_last);
    assign status.scatter_done = phase_reg && (eidx_reg == last_idx);
    assign status.sort_done    = ({1'b0, shift_reg} + (SH_W+1)'(step_bits)) >= (SH_W+1)'(32);
    assign status.emit_last    = phase_reg && (eidx_reg == last_idx);

    // count, prefix, scatter and emit steps: phase 0 reads, phase 1 writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            over_reg   <= 1'b0;
            src_b_reg  <= 1'b0;
            shift_reg  <= '0;
            bidx_reg   <= '0;
            eidx_reg   <= '0;
            sum_reg    <= '0;
            phase_reg  <= 1'b0;
            desc_reg   <= 1'b0;
            emit_valid <= 1'b0;
        end
        else
        begin
            emit_valid <= cmd.emit_step && phase_reg;

            if (cmd.finish)
            begin
                count_reg <= '0;
            end
            else if (cmd.load && count_reg < CAP_C)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            if (cmd.finish)
            begin
                over_reg <= 1'b0;
            end
            else if (cmd.load && !(count_reg < CAP_C))
            begin
                over_reg <= 1'b1;
            end

            if (cmd.start_sort)
            begin
                desc_reg <= descending;
            end

            if (cmd.start_sort)
            begin
                src_b_reg <= 1'b0;
            end
            else if (cmd.next_pass)
            begin
                src_b_reg <= ~src_b_reg;
            end

            if (cmd.start_sort)
            begin
                shift_reg <= '0;
            end
            else if (cmd.next_pass)
            begin
                shift_reg <= status.sort_done ? '0 : shift_reg + step_bits;
            end

            if (cmd.start_sort)
            begin
                bidx_reg <= '0;
            end
            else if (cmd.clear_step)
            begin
                bidx_reg <= status.clear_done ? '0 : bidx_reg + (DIGIT_BITS+1)'(1);
            end
            else if (cmd.prefix_step && phase_reg)
            begin
                bidx_reg <= status.prefix_done ? '0 : bidx_reg + (DIGIT_BITS+1)'(1);
            end

            if (cmd.start_sort || cmd.finish)
            begin
                eidx_reg <= '0;
            end
            else if ((cmd.count_step || cmd.scatter_step || cmd.emit_step) && phase_reg)
            begin
                eidx_reg <= (eidx_reg == last_idx) ? '0 : eidx_reg + CNT_W'(1);
            end

            if (cmd.prefix_step && phase_reg)
            begin
                sum_reg <= sum_reg + brd_reg;
            end
            else if ((cmd.count_step || cmd.scatter_step) && status.count_done)
            begin
                sum_reg <= '0;
            end

            if (cmd.start_sort || cmd.finish)
            begin
                phase_reg <= 1'b0;
            end
            else if (cmd.count_step || cmd.scatter_step || cmd.emit_step || cmd.prefix_step)
            begin
                phase_reg <= ~phase_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_step && phase_reg)
        begin
            emit_value   <= rd_reg;
            emit_end     <= status.emit_last;
            emit_dropped <= over_reg;
        end
    end
endmodule

/* design/signed_radix_sorter_core.sv */
// Top level of the signed radix sorter: APB register, controller, datapath, output stage.
// Loading takes one cycle per transfer; after the last one the n elements sort in three passes:
// each pass clears the bucket counters, counts, prefixes the counters (2048, 2048, 1024) and
// scatters. Results then follow through the registered output stage, and output stalls hold
// them back. Reset (rst_n low, asynchronous) empties the set, clears the dropped flag and sets
// ascending order; buffers are undefined until written.
module signed_radix_sorter_core #(
    parameter int CAPACITY   = srs_pkg::DEF_CAPACITY,
    parameter int DIGIT_BITS = srs_pkg::DEF_DIGIT_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    srs_in_if.sink      in_ch,
    srs_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import srs_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    desc_reg;
    logic    in_rdy;
    logic    emitting;
    logic    e_valid;
    logic [31:0] e_value;
    logic    e_end;
    logic    e_drop;
    logic    ov_reg;
    logic [31:0] ov_value_reg;
    logic    ov_end_reg;
    logic    ov_drop_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_DESCENDING) ? {31'd0, desc_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr == ADDR_DESCENDING)
        begin
            desc_reg <= pwdata[0];
        end
    end

    assign in_ch.ready = in_rdy;

    srs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_ch.valid && in_rdy),
        .in_last  (in_ch.is_last),
        .out_busy (ov_reg && !out_ch.ready),
        .status   (status),
        .cmd      (cmd),
        .in_ready (in_rdy),
        .emitting (emitting)
    );

    srs_datapath #(
        .CAPACITY   (CAPACITY),
        .DIGIT_BITS (DIGIT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_value     (in_ch.value),
        .descending   (desc_reg),
        .status       (status),
        .emit_valid   (e_valid),
        .emit_value   (e_value),
        .emit_end     (e_end),
        .emit_dropped (e_drop)
    );

    // output register; emit stalls while it is full and not taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (e_valid)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_valid)
        begin
            ov_value_reg <= e_value;
            ov_end_reg   <= e_end;
            ov_drop_reg  <= e_drop;
        end
    end

    assign out_ch.valid        = ov_reg && (emitting || 1'b1);
    assign out_ch.sorted_value = ov_value_reg;
    assign out_ch.end_of_set   = ov_end_reg;
    assign out_ch.dropped      = ov_drop_reg;
endmodule
